/* rtl/enc_ext_pkg.sv */
`default_nettype none

package enc_ext_pkg;

  localparam int unsigned Channels      = 4;
  localparam int unsigned ChanWidth     = 2;
  localparam int unsigned ChanSlots     = 2 ** ChanWidth;
  localparam int unsigned CountWidth    = 32;
  localparam int unsigned NarrowWidth   = 16;
  localparam int unsigned ProdWidth     = 64;
  localparam int unsigned SpeedShift    = 8;
  localparam int unsigned AddrWidth     = 3;
  localparam int unsigned DataWidth     = 32;
  localparam int unsigned MaskWidth     = 4;

  localparam logic [MaskWidth-1:0]  WideMaskReset = MaskWidth'(9);
  localparam logic [CountWidth-1:0] RpmScaleReset = CountWidth'(384000);

  typedef enum logic [0:0] {
    REG_WIDE_MASK = 1'b0,
    REG_RPM_SCALE = 1'b1
  } reg_sel_e;

  typedef enum logic [0:0] {
    KIND_SAMPLE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [ChanWidth-1:0]   channel;
    logic [CountWidth-1:0]  raw_count;
  } in_req_t;

  typedef struct packed {
    logic [ChanWidth-1:0]         channel_out;
    logic signed [CountWidth-1:0] position;
    logic signed [CountWidth-1:0] step_delta;
    logic signed [CountWidth-1:0] speed_rpm_q8;
  } out_rsp_t;

  typedef struct packed {
    logic [CountWidth-1:0] prev_raw;
    logic [CountWidth-1:0] position;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/enc_ext_ram.sv */
`default_nettype none

module enc_ext_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/encoder_count_extender_top.sv */
`default_nettype none

// Extended position counter for four encoder channels. Each request carries a
// channel's raw hardware count (or a clear); the result gives the wrapped
// 32-bit position, the step since the previous sample, and the speed in
// 1/256 rpm (step times the Q16.16 rpm_scale register, floored, saturated).
// One request is taken every cycle while in_stall_o is low. The request and
// its state memory read are registered; the count update and 32x33 multiply
// feed the product register; shift and saturation feed the output register.
// Back-to-back requests to the same channel are forwarded around the memory.
// Per-channel state (previous raw count, position) sits in a four-entry
// memory whose entries read as zero until first written after reset.
module encoder_count_extender_top (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,

  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire enc_ext_pkg::in_req_t                  in_req_i,

  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output enc_ext_pkg::out_rsp_t                      out_rsp_o,

  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [enc_ext_pkg::AddrWidth-1:0]     paddr,
  input  wire logic [enc_ext_pkg::DataWidth-1:0]     pwdata,
  output logic      [enc_ext_pkg::DataWidth-1:0]     prdata,
  output logic                                       pready
);

  localparam int unsigned CW = enc_ext_pkg::CountWidth;
  localparam int unsigned NW = enc_ext_pkg::NarrowWidth;
  localparam int unsigned PW = enc_ext_pkg::ProdWidth;
  localparam int unsigned SH = enc_ext_pkg::SpeedShift;

  // Configuration registers
  logic [enc_ext_pkg::MaskWidth-1:0] wide_mask_q;
  logic [CW-1:0]                     rpm_scale_q;
  enc_ext_pkg::reg_sel_e             reg_sel;
  logic                              cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = enc_ext_pkg::reg_sel_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      enc_ext_pkg::REG_WIDE_MASK: prdata = enc_ext_pkg::DataWidth'(wide_mask_q);
      enc_ext_pkg::REG_RPM_SCALE: prdata = rpm_scale_q;
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_mask_q <= enc_ext_pkg::WideMaskReset;
      rpm_scale_q <= enc_ext_pkg::RpmScaleReset;
    end else if (cfg_write) begin
      unique case (reg_sel)
        enc_ext_pkg::REG_WIDE_MASK: wide_mask_q <= pwdata[enc_ext_pkg::MaskWidth-1:0];
        enc_ext_pkg::REG_RPM_SCALE: rpm_scale_q <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_ready, s2_ready, s1_ready, in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_accept  = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  // State memory
  enc_ext_pkg::in_req_t              s1_req_q;
  logic                              s1_fwd_hit_q;
  enc_ext_pkg::entry_t               s1_fwd_q;
  logic                              s1_rd_valid_q;
  logic [enc_ext_pkg::ChanSlots-1:0] entry_valid_q;
  logic                              mem_we;
  enc_ext_pkg::entry_t               mem_wdata;
  logic [$bits(enc_ext_pkg::entry_t)-1:0] mem_rdata;

  enc_ext_ram #(
    .Width ($bits(enc_ext_pkg::entry_t)),
    .Depth (enc_ext_pkg::ChanSlots)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s1_req_q.channel),
    .wdata_i (mem_wdata),
    .re_i    (in_accept),
    .raddr_i (in_req_i.channel),
    .rdata_o (mem_rdata)
  );

  // Stage 1: update count
  enc_ext_pkg::entry_t   cur_entry;
  logic                  in_range;
  logic                  is_clear;
  logic                  is_wide;
  logic [CW-1:0]         raw_diff;
  logic signed [CW-1:0]  delta;
  logic [CW-1:0]         new_pos;
  logic signed [CW-1:0]  s1_delta;
  logic [CW-1:0]         s1_pos;
  logic signed [PW-1:0]  prod_d;

  always_comb begin
    if (s1_fwd_hit_q) begin
      cur_entry = s1_fwd_q;
    end else if (s1_rd_valid_q) begin
      cur_entry = enc_ext_pkg::entry_t'(mem_rdata);
    end else begin
      cur_entry = '0;
    end
    in_range = 32'(s1_req_q.channel) < enc_ext_pkg::Channels;
    is_clear = s1_req_q.kind == enc_ext_pkg::KIND_CLEAR;
    is_wide  = wide_mask_q[s1_req_q.channel];
    raw_diff = s1_req_q.raw_count - cur_entry.prev_raw;
    if (is_wide) begin
      delta = raw_diff;
    end else begin
      delta = {{(CW-NW){raw_diff[NW-1]}}, raw_diff[NW-1:0]};
    end
    new_pos = cur_entry.position + delta;
    if (is_clear) begin
      mem_wdata = '0;
    end else begin
      mem_wdata = '{prev_raw: s1_req_q.raw_count, position: new_pos};
    end
    if (in_range && !is_clear) begin
      s1_delta = delta;
      s1_pos   = new_pos;
    end else begin
      s1_delta = '0;
      s1_pos   = '0;
    end
    prod_d = s1_delta * $signed({1'b0, rpm_scale_q});
  end

  assign mem_we = s1_valid_q && s2_ready && in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      entry_valid_q <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (mem_we) begin
        entry_valid_q[s1_req_q.channel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q      <= in_req_i;
      s1_fwd_hit_q  <= mem_we && (s1_req_q.channel == in_req_i.channel);
      s1_fwd_q      <= mem_wdata;
      s1_rd_valid_q <= entry_valid_q[in_req_i.channel];
    end
  end

  // Stage 2: product register
  logic [enc_ext_pkg::ChanWidth-1:0] s2_chan_q;
  logic [CW-1:0]                     s2_pos_q;
  logic [CW-1:0]                     s2_delta_q;
  logic signed [PW-1:0]              s2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_chan_q  <= s1_req_q.channel;
      s2_pos_q   <= s1_pos;
      s2_delta_q <= s1_delta;
      s2_prod_q  <= prod_d;
    end
  end

  // Stage 3: floor shift, saturate, output register
  logic [CW-1:0]        speed;
  logic                 prod_fits;
  enc_ext_pkg::out_rsp_t out_rsp_q;

  always_comb begin
    prod_fits = (&s2_prod_q[PW-1:CW+SH-1]) || !(|s2_prod_q[PW-1:CW+SH-1]);
    if (prod_fits) begin
      speed = s2_prod_q[CW+SH-1:SH];
    end else if (s2_prod_q[PW-1]) begin
      speed = {1'b1, {(CW-1){1'b0}}};
    end else begin
      speed = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s2_valid_q) begin
      out_rsp_q <= '{channel_out:  s2_chan_q,
                     position:     s2_pos_q,
                     step_delta:   s2_delta_q,
                     speed_rpm_q8: speed};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

/* rtl/enc_ext_checker.sv */
`default_nettype none

module enc_ext_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  input  wire enc_ext_pkg::out_rsp_t             out_rsp_o,
  input  wire logic                              pready
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  a_zero_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.step_delta == 0) |-> out_rsp_o.speed_rpm_q8 == 0)
    else $error("speed without step");

  a_speed_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.speed_rpm_q8[31] |-> out_rsp_o.step_delta[31])
    else $error("negative speed on forward step");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_valid_i) && !$past(in_valid_i, 2) && !$past(in_valid_i, 3) &&
    !$past(out_valid_o) |-> !out_valid_o)
    else $error("result without request");

endmodule

bind encoder_count_extender_top enc_ext_checker u_checker (.*);

`default_nettype wire
